// ===== rtl/ebalu_pkg.sv =====
// shared types, opcodes and constants for the eight-bit cpu alu with flags
// no dependencies; imported by ebalu_core and the top level
package ebalu_pkg;

  // operation codes, values 18 to 31 are unused
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_CP    = 5'd4,
    OP_AND   = 5'd5,
    OP_OR    = 5'd6,
    OP_XOR   = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RR    = 5'd10,
    OP_RRA   = 5'd11,
    OP_SRL   = 5'd12,
    OP_SWAP  = 5'd13,
    OP_DAA   = 5'd14,
    OP_CPL   = 5'd15,
    OP_ADD16 = 5'd16,
    OP_ADDSP = 5'd17
  } alu_op_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [7:0] DAA_LO     = 8'h06;
  localparam logic [7:0] DAA_HI     = 8'h60;
  localparam logic [3:0] DAA_NIB_MAX = 4'h9;
  localparam logic [7:0] DAA_BYTE_MAX = 8'h99;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [3:0]  flags_in;
    logic [15:0] operand_b;
    logic [15:0] operand_a;
    logic [4:0]  operation;
  } alu_item_t;

  typedef struct packed {
    logic        writes_result;
    logic [3:0]  flags_out;
    logic [15:0] result;
  } alu_result_t;

  function automatic logic is_zero(input logic [7:0] v);
    return (v == 8'h00);
  endfunction

endpackage

// ===== rtl/eight_bit_cpu_alu_with_flags.sv =====
// top level of the eight-bit cpu alu with flags: stream ports, input and result registers
// depends on ebalu_pkg and ebalu_core
//
// usage
//   s_* carries one operation per beat: opcode, two operands and the incoming flags
//   m_* returns one beat per operation: result, new flags and the write mark
//   a beat moves on a rising edge where tvalid and tready are both high
// path
//   an accepted beat lands in the input register, the datapath works on it
//   combinationally and the result register presents it when it next loads,
//   which raises m_tvalid
// throughput
//   one beat per cycle while m_tready is high; the only work is a single pass
//   through the adders and muxes of ebalu_core between the two registers
// stalls
//   when m_tready is low the result register holds; an empty input register
//   still takes one more beat, then s_tready drops until the result side drains
// reset
//   rst clears both valid flags; no beat is in flight afterwards
module eight_bit_cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[4:0], operand_a[20:5], operand_b[36:21], flags_in[40:37], zero[47:41]
  input  logic [ebalu_pkg::IN_TDATA_W-1:0]  s_tdata,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // result[15:0], flags_out[19:16], writes_result[20], zero[23:21]
  output logic [ebalu_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ebalu_pkg::*;

  alu_item_t   item;
  logic        item_valid;
  alu_result_t core_res;
  alu_result_t out_q;
  logic        out_valid;
  logic        out_load;
  logic        in_load;

  // result register can load when empty or being drained this cycle
  assign out_load = !out_valid || m_tready;
  // input register can load when empty or passing its beat on
  assign in_load  = !item_valid || out_load;
  assign s_tready = in_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_load) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_tvalid) begin
      item <= alu_item_t'(s_tdata[$bits(alu_item_t)-1:0]);
    end
  end

  ebalu_core u_core (
    .item (item),
    .res  (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && item_valid) begin
      out_q <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - $bits(alu_result_t)){1'b0}}, out_q};

endmodule

// ===== rtl/ebalu_core.sv =====
// combinational datapath of the alu: result, new flags and write mark
// depends on ebalu_pkg
module ebalu_core (
  input  ebalu_pkg::alu_item_t   item,
  output ebalu_pkg::alu_result_t res
);
  import ebalu_pkg::*;

  alu_op_t     op;
  logic [7:0]  a8, b8;
  logic        f_z, f_n, f_h, f_c;
  logic [8:0]  sum9;
  logic [8:0]  sub_s;
  logic [9:0]  diff10;
  logic [7:0]  adj;
  logic [7:0]  daa_r;
  logic [16:0] sum17;
  logic [15:0] sp_off, sp_sum, sp_x;
  logic [7:0]  r8;

  assign op  = alu_op_t'(item.operation);
  assign a8  = item.operand_a[7:0];
  assign b8  = item.operand_b[7:0];
  assign f_z = item.flags_in[FLAG_Z];
  assign f_n = item.flags_in[FLAG_N];
  assign f_h = item.flags_in[FLAG_H];
  assign f_c = item.flags_in[FLAG_C];

  // 8-bit adder, carry in only for adc
  assign sum9 = {1'b0, a8} + {1'b0, b8} + {8'h00, f_c & (op == OP_ADC)};

  // subtract with borrow out of the top of a 10-bit difference
  assign sub_s  = {1'b0, b8} + {8'h00, f_c & (op == OP_SBC)};
  assign diff10 = {2'b00, a8} - {1'b0, sub_s};

  always_comb begin
    adj = 8'h00;
    if (f_h || (!f_n && (a8[3:0] > DAA_NIB_MAX))) begin
      adj = adj | DAA_LO;
    end
    if (f_c || (!f_n && (a8 > DAA_BYTE_MAX))) begin
      adj = adj | DAA_HI;
    end
  end
  assign daa_r = f_n ? (a8 - adj) : (a8 + adj);

  assign sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
  assign sp_off = {{8{b8[7]}}, b8};
  assign sp_sum = item.operand_a + sp_off;
  assign sp_x   = item.operand_a ^ sp_off ^ sp_sum;

  always_comb begin
    r8  = 8'h00;
    res = '0;
    res.writes_result = 1'b1;
    unique case (op) inside
      OP_ADD, OP_ADC: begin
        r8 = sum9[7:0];
        res.flags_out = {is_zero(r8), 1'b0, a8[4] ^ b8[4] ^ sum9[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8 = diff10[7:0];
        res.flags_out = {is_zero(r8), 1'b1, a8[4] ^ b8[4] ^ diff10[4], diff10[9]};
        res.writes_result = (op != OP_CP);
      end
      OP_AND: begin
        r8 = a8 & b8;
        res.flags_out = {is_zero(r8), 1'b0, 1'b1, 1'b0};
      end
      OP_OR: begin
        r8 = a8 | b8;
        res.flags_out = {is_zero(r8), 3'b000};
      end
      OP_XOR: begin
        r8 = a8 ^ b8;
        res.flags_out = {is_zero(r8), 3'b000};
      end
      OP_INC: begin
        r8 = a8 + 8'h01;
        res.flags_out = {is_zero(r8), 1'b0, a8[3:0] == 4'hF, f_c};
      end
      OP_DEC: begin
        r8 = a8 - 8'h01;
        res.flags_out = {is_zero(r8), 1'b1, a8[3:0] == 4'h0, f_c};
      end
      OP_RR: begin
        r8 = {f_c, a8[7:1]};
        res.flags_out = {is_zero(r8), 2'b00, a8[0]};
      end
      OP_RRA: begin
        r8 = {f_c, a8[7:1]};
        res.flags_out = {3'b000, a8[0]};
      end
      OP_SRL: begin
        r8 = {1'b0, a8[7:1]};
        res.flags_out = {is_zero(r8), 2'b00, a8[0]};
      end
      OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        res.flags_out = {is_zero(r8), 3'b000};
      end
      OP_DAA: begin
        r8 = daa_r;
        res.flags_out = {is_zero(r8), f_n, 1'b0, adj[5]};
      end
      OP_CPL: begin
        r8 = ~a8;
        res.flags_out = {f_z, 1'b1, 1'b1, f_c};
      end
      OP_ADD16: begin
        res.flags_out = {f_z, 1'b0,
                         item.operand_a[12] ^ item.operand_b[12] ^ sum17[12],
                         sum17[16]};
      end
      OP_ADDSP: begin
        res.flags_out = {2'b00, sp_x[4], sp_x[8]};
      end
      default: begin
        // unused codes pass the flags and write nothing
        res.flags_out     = item.flags_in;
        res.writes_result = 1'b0;
      end
    endcase
    if (op == OP_ADD16) begin
      res.result = sum17[15:0];
    end else if (op == OP_ADDSP) begin
      res.result = sp_sum;
    end else begin
      res.result = {8'h00, r8};
    end
  end

endmodule
